>>> sv/slbr_pkg.sv
// ----------------------------------------------------------------------------
// slbr_pkg : shared types and constants of the styled line/box rasterizer
// Operation codes, register map, controller states and the command/status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package slbr_pkg;

   localparam int COORD_W    = 12;
   localparam int PIX_W      = 4;
   localparam int STYLE_W    = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [3:0] STYLE_TOP_BIT = 4'd15;

   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] REG_VIEW_LEFT     = 3'd2;
   localparam logic [2:0] REG_VIEW_TOP      = 3'd3;
   localparam logic [2:0] REG_VIEW_RIGHT    = 3'd4;
   localparam logic [2:0] REG_VIEW_BOTTOM   = 3'd5;
   localparam logic [2:0] REG_DEFAULT_COLOR = 3'd6;

   localparam logic [9:0] RST_SCREEN_WIDTH  = 10'd320;
   localparam logic [8:0] RST_SCREEN_HEIGHT = 9'd200;
   localparam logic [9:0] RST_VIEW_LEFT     = 10'd0;
   localparam logic [8:0] RST_VIEW_TOP      = 9'd0;
   localparam logic [9:0] RST_VIEW_RIGHT    = 10'd319;
   localparam logic [8:0] RST_VIEW_BOTTOM   = 9'd199;
   localparam logic [3:0] RST_DEFAULT_COLOR = 4'd3;

   typedef enum logic [1:0] {
      OP_LINE = 2'd0,
      OP_BOX  = 2'd1,
      OP_FILL = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      SEG_LINE,
      SEG_TOP,
      SEG_RIGHT,
      SEG_BOTTOM,
      SEG_LEFT,
      SEG_ROW
   } seg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEG_LOAD,
      ST_RUN,
      ST_FILL_INIT,
      ST_FILL_CHECK,
      ST_READ,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [9:0] screen_width;
      logic [8:0] screen_height;
      logic [9:0] view_left;
      logic [8:0] view_top;
      logic [9:0] view_right;
      logic [8:0] view_bottom;
      logic [3:0] default_color;
   } cfg_type;

   typedef struct packed {
      op_type                     op;
      logic signed [COORD_W-1:0]  x_start;
      logic signed [COORD_W-1:0]  y_start;
      logic signed [COORD_W-1:0]  x_end;
      logic signed [COORD_W-1:0]  y_end;
      logic                       has_color;
      logic [PIX_W-1:0]           color;
      logic [STYLE_W-1:0]         line_style;
   } item_type;

   typedef struct packed {
      logic    accept;
      logic    seg_load;
      seg_type seg;
      logic    step;
      logic    row_init;
      logic    row_inc;
      logic    read_issue;
      logic    rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   at_end;
      logic   row_done;
      logic   rd_done;
      logic   clr_busy;
   } status_type;

endpackage

`default_nettype wire

>>> sv/slbr_if.sv
// ----------------------------------------------------------------------------
// slbr_if : request and response channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface slbr_req_if;
   logic                                valid;
   logic                                ready;
   slbr_pkg::op_type                    op;
   logic signed [slbr_pkg::COORD_W-1:0] x_start;
   logic signed [slbr_pkg::COORD_W-1:0] y_start;
   logic signed [slbr_pkg::COORD_W-1:0] x_end;
   logic signed [slbr_pkg::COORD_W-1:0] y_end;
   logic                                has_color;
   logic [slbr_pkg::PIX_W-1:0]          color;
   logic [slbr_pkg::STYLE_W-1:0]        line_style;

   modport source (output valid, op, x_start, y_start, x_end, y_end, has_color, color,
                   line_style, input ready);
   modport sink   (input valid, op, x_start, y_start, x_end, y_end, has_color, color,
                   line_style, output ready);
endinterface

interface slbr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [slbr_pkg::PIX_W-1:0] pixel_value;
   logic                       off_screen;

   modport source (output valid, pixel_value, off_screen, input ready);
   modport sink   (input valid, pixel_value, off_screen, output ready);
endinterface

`default_nettype wire

>>> sv/slbr_csr.sv
// ----------------------------------------------------------------------------
// slbr_csr : configuration registers
// APB-style write/read of screen size, viewport and default colour.
// ----------------------------------------------------------------------------
`default_nettype none

module slbr_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [slbr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [slbr_pkg::CSR_DATA_W-1:0]     pwdata,
   output      logic [slbr_pkg::CSR_DATA_W-1:0]     prdata,
   output      logic                                pready,
   output      slbr_pkg::cfg_type                   cfg
);

   slbr_pkg::cfg_type cfg_ff;
   slbr_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[4:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            slbr_pkg::REG_SCREEN_WIDTH:  cfg_in.screen_width  = pwdata[9:0];
            slbr_pkg::REG_SCREEN_HEIGHT: cfg_in.screen_height = pwdata[8:0];
            slbr_pkg::REG_VIEW_LEFT:     cfg_in.view_left     = pwdata[9:0];
            slbr_pkg::REG_VIEW_TOP:      cfg_in.view_top      = pwdata[8:0];
            slbr_pkg::REG_VIEW_RIGHT:    cfg_in.view_right    = pwdata[9:0];
            slbr_pkg::REG_VIEW_BOTTOM:   cfg_in.view_bottom   = pwdata[8:0];
            slbr_pkg::REG_DEFAULT_COLOR: cfg_in.default_color = pwdata[3:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         slbr_pkg::REG_SCREEN_WIDTH:  prdata = 32'(cfg_ff.screen_width);
         slbr_pkg::REG_SCREEN_HEIGHT: prdata = 32'(cfg_ff.screen_height);
         slbr_pkg::REG_VIEW_LEFT:     prdata = 32'(cfg_ff.view_left);
         slbr_pkg::REG_VIEW_TOP:      prdata = 32'(cfg_ff.view_top);
         slbr_pkg::REG_VIEW_RIGHT:    prdata = 32'(cfg_ff.view_right);
         slbr_pkg::REG_VIEW_BOTTOM:   prdata = 32'(cfg_ff.view_bottom);
         slbr_pkg::REG_DEFAULT_COLOR: prdata = 32'(cfg_ff.default_color);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= slbr_pkg::RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= slbr_pkg::RST_SCREEN_HEIGHT;
         cfg_ff.view_left     <= slbr_pkg::RST_VIEW_LEFT;
         cfg_ff.view_top      <= slbr_pkg::RST_VIEW_TOP;
         cfg_ff.view_right    <= slbr_pkg::RST_VIEW_RIGHT;
         cfg_ff.view_bottom   <= slbr_pkg::RST_VIEW_BOTTOM;
         cfg_ff.default_color <= slbr_pkg::RST_DEFAULT_COLOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/slbr_ctrl.sv
// ----------------------------------------------------------------------------
// slbr_ctrl : operation sequencer
// Walks each request through its segments, rows or read, and owns the
// request/response handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module slbr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire slbr_pkg::status_type status,
   output      slbr_pkg::cmd_type    cmd
);

   slbr_pkg::state_type state_ff, state_in;
   slbr_pkg::seg_type   seg_ff, seg_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slbr_pkg::ST_IDLE;
         seg_ff       <= slbr_pkg::SEG_LINE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      seg_in    = seg_ff;
      cmd       = '0;
      cmd.seg   = seg_ff;
      req_ready = 1'b0;

      unique case (state_ff)
         slbr_pkg::ST_IDLE: begin
            req_ready = !status.clr_busy;
            if (req_valid && !status.clr_busy) begin
               cmd.accept = 1'b1;
               state_in   = slbr_pkg::ST_DISPATCH;
            end
         end
         slbr_pkg::ST_DISPATCH: begin
            unique case (status.op)
               slbr_pkg::OP_LINE: begin
                  seg_in   = slbr_pkg::SEG_LINE;
                  state_in = slbr_pkg::ST_SEG_LOAD;
               end
               slbr_pkg::OP_BOX: begin
                  seg_in   = slbr_pkg::SEG_TOP;
                  state_in = slbr_pkg::ST_SEG_LOAD;
               end
               slbr_pkg::OP_FILL: state_in = slbr_pkg::ST_FILL_INIT;
               slbr_pkg::OP_READ: state_in = slbr_pkg::ST_READ;
               default:           state_in = slbr_pkg::ST_FINISH;
            endcase
         end
         slbr_pkg::ST_SEG_LOAD: begin
            cmd.seg_load = 1'b1;
            state_in     = slbr_pkg::ST_RUN;
         end
         slbr_pkg::ST_RUN: begin
            cmd.step = 1'b1;
            if (status.at_end) begin
               if (status.op == slbr_pkg::OP_FILL) begin
                  cmd.row_inc = 1'b1;
                  state_in    = slbr_pkg::ST_FILL_CHECK;
               end else if (status.op == slbr_pkg::OP_BOX) begin
                  state_in = slbr_pkg::ST_SEG_LOAD;
                  case (seg_ff)
                     slbr_pkg::SEG_TOP:    seg_in = slbr_pkg::SEG_RIGHT;
                     slbr_pkg::SEG_RIGHT:  seg_in = slbr_pkg::SEG_BOTTOM;
                     slbr_pkg::SEG_BOTTOM: seg_in = slbr_pkg::SEG_LEFT;
                     default:              state_in = slbr_pkg::ST_FINISH;
                  endcase
               end else begin
                  state_in = slbr_pkg::ST_FINISH;
               end
            end
         end
         slbr_pkg::ST_FILL_INIT: begin
            cmd.row_init = 1'b1;
            state_in     = slbr_pkg::ST_FILL_CHECK;
         end
         slbr_pkg::ST_FILL_CHECK: begin
            if (status.row_done) begin
               state_in = slbr_pkg::ST_FINISH;
            end else begin
               seg_in   = slbr_pkg::SEG_ROW;
               state_in = slbr_pkg::ST_SEG_LOAD;
            end
         end
         slbr_pkg::ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = slbr_pkg::ST_READ_WAIT;
         end
         slbr_pkg::ST_READ_WAIT: begin
            if (status.rd_done) begin
               state_in = slbr_pkg::ST_FINISH;
            end
         end
         slbr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = slbr_pkg::ST_IDLE;
            end
         end
         default: state_in = slbr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

`default_nettype wire

>>> sv/slbr_fb.sv
// ----------------------------------------------------------------------------
// slbr_fb : frame store
// Single-port 4-bit pixel memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module slbr_fb #(
   parameter int DEPTH = 224000
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         we,
   input  wire logic                         re,
   input  wire logic [$clog2(DEPTH)-1:0]     addr,
   input  wire logic [slbr_pkg::PIX_W-1:0]   wdata,
   output      logic [slbr_pkg::PIX_W-1:0]   rdata,
   output      logic                         clr_busy
);

   localparam int AW = $clog2(DEPTH);

   logic [slbr_pkg::PIX_W-1:0] mem [DEPTH];
   logic [slbr_pkg::PIX_W-1:0] rdata_ff;
   logic [AW-1:0]              clr_cnt_ff;
   logic                       clr_busy_ff;

   assign rdata    = rdata_ff;
   assign clr_busy = clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/slbr_dp.sv
// ----------------------------------------------------------------------------
// slbr_dp : rasterizer datapath
// Request registers, Bresenham stepper, row counter, three-stage pixel
// pipeline (clip, row offset, address) into the frame store, response regs.
// ----------------------------------------------------------------------------
`default_nettype none

module slbr_dp #(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 350
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire slbr_pkg::cfg_type           cfg,
   input  wire slbr_pkg::item_type          req_item,
   input  wire slbr_pkg::cmd_type           cmd,
   output      slbr_pkg::status_type        status,
   output      logic [slbr_pkg::PIX_W-1:0]  rsp_pixel,
   output      logic                        rsp_off
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int CW    = slbr_pkg::COORD_W + 1;
   localparam int ERRW  = slbr_pkg::COORD_W + 3;
   localparam int PW    = slbr_pkg::PIX_W;
   localparam int KW    = slbr_pkg::COORD_W;

   // request
   slbr_pkg::op_type          it_op_ff;
   logic signed [KW-1:0]      it_xs_ff, it_ys_ff, it_xe_ff, it_ye_ff;
   logic [PW-1:0]             it_col_ff;
   logic [slbr_pkg::STYLE_W-1:0] it_style_ff;

   // stepper
   logic signed [KW-1:0]      cur_x_ff, cur_y_ff, end_x_ff, end_y_ff;
   logic signed [ERRW-1:0]    dx_ff, dy_ff, err_ff;
   logic                      sx_neg_ff, sy_neg_ff;
   logic [3:0]                bit_ff;

   // rows
   logic signed [KW-1:0]      row_ff, row_hi_ff;

   // pipeline
   logic                      s1_wr_ff, s1_rd_ff, s1_off_ff;
   logic [XW-1:0]             s1_x_ff;
   logic [YW-1:0]             s1_y_ff;
   logic [PW-1:0]             s1_col_ff;
   logic                      s2_wr_ff, s2_rd_ff, s2_off_ff;
   logic [XW-1:0]             s2_x_ff;
   logic [AW-1:0]             s2_prod_ff;
   logic [PW-1:0]             s2_col_ff;
   logic                      s3_rd_ff, s3_off_ff;

   logic [PW-1:0]             hold_pix_ff, rsp_pixel_ff;
   logic                      hold_off_ff, rsp_off_ff;

   logic [WW-1:0]             eff_w;
   logic [HW-1:0]             eff_h;
   logic signed [KW-1:0]      sx0, sy0, sx1, sy1;
   logic signed [KW:0]        ddx, ddy;
   logic [KW-1:0]             adx, ady;
   logic signed [ERRW:0]      e2, dxw, dyw;
   logic                      mv_x, mv_y;
   logic signed [KW-1:0]      lo, hi, h_last;
   logic signed [KW-1:0]      pt_x, pt_y;
   logic signed [CW-1:0]      xc, yc;
   logic                      on_scr, in_view, plot_wr;
   logic [AW-1:0]             ya, wa;
   logic [AW-1:0]             fb_addr;
   logic [PW-1:0]             fb_rdata;
   logic                      fb_busy;

   assign eff_w = (cfg.screen_width > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.screen_width);
   assign eff_h = (cfg.screen_height > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                                                   : HW'(cfg.screen_height);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         it_op_ff    <= req_item.op;
         it_xs_ff    <= req_item.x_start;
         it_ys_ff    <= req_item.y_start;
         it_xe_ff    <= req_item.x_end;
         it_ye_ff    <= req_item.y_end;
         it_col_ff   <= req_item.has_color ? req_item.color : cfg.default_color;
         it_style_ff <= req_item.line_style;
      end
   end

   // segment endpoints
   always_comb begin
      unique case (cmd.seg)
         slbr_pkg::SEG_TOP: begin
            sx0 = it_xs_ff; sy0 = it_ys_ff; sx1 = it_xe_ff; sy1 = it_ys_ff;
         end
         slbr_pkg::SEG_RIGHT: begin
            sx0 = it_xe_ff; sy0 = it_ys_ff; sx1 = it_xe_ff; sy1 = it_ye_ff;
         end
         slbr_pkg::SEG_BOTTOM: begin
            sx0 = it_xe_ff; sy0 = it_ye_ff; sx1 = it_xs_ff; sy1 = it_ye_ff;
         end
         slbr_pkg::SEG_LEFT: begin
            sx0 = it_xs_ff; sy0 = it_ye_ff; sx1 = it_xs_ff; sy1 = it_ys_ff;
         end
         slbr_pkg::SEG_ROW: begin
            sx0 = it_xs_ff; sy0 = row_ff; sx1 = it_xe_ff; sy1 = row_ff;
         end
         default: begin
            sx0 = it_xs_ff; sy0 = it_ys_ff; sx1 = it_xe_ff; sy1 = it_ye_ff;
         end
      endcase
   end

   assign ddx = (KW+1)'(sx1) - (KW+1)'(sx0);
   assign ddy = (KW+1)'(sy1) - (KW+1)'(sy0);
   assign adx = ddx[KW] ? KW'(-ddx) : KW'(ddx);
   assign ady = ddy[KW] ? KW'(-ddy) : KW'(ddy);

   assign e2   = {err_ff, 1'b0};
   assign dxw  = (ERRW+1)'(dx_ff);
   assign dyw  = (ERRW+1)'(dy_ff);
   assign mv_x = (e2 >= dyw);
   assign mv_y = (e2 <= dxw);

   assign status.at_end = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);

   always_ff @(posedge clock) begin
      if (cmd.seg_load) begin
         cur_x_ff  <= sx0;
         cur_y_ff  <= sy0;
         end_x_ff  <= sx1;
         end_y_ff  <= sy1;
         dx_ff     <= $signed(ERRW'(adx));
         dy_ff     <= -$signed(ERRW'(ady));
         err_ff    <= $signed(ERRW'(adx)) - $signed(ERRW'(ady));
         sx_neg_ff <= !(sx0 < sx1);
         sy_neg_ff <= !(sy0 < sy1);
         bit_ff    <= slbr_pkg::STYLE_TOP_BIT;
      end else if (cmd.step) begin
         bit_ff <= bit_ff - 1'b1;
         if (!status.at_end) begin
            err_ff <= err_ff + (mv_x ? dy_ff : '0) + (mv_y ? dx_ff : '0);
            if (mv_x) begin
               cur_x_ff <= sx_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
            if (mv_y) begin
               cur_y_ff <= sy_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
         end
      end
   end

   // filled box rows, clamped to the screen
   assign lo     = (it_ys_ff < it_ye_ff) ? it_ys_ff : it_ye_ff;
   assign hi     = (it_ys_ff < it_ye_ff) ? it_ye_ff : it_ys_ff;
   assign h_last = $signed(KW'(eff_h)) - $signed(KW'(1));

   always_ff @(posedge clock) begin
      if (cmd.row_init) begin
         row_ff    <= lo[KW-1] ? '0 : lo;
         row_hi_ff <= (hi > h_last) ? h_last : hi;
      end else if (cmd.row_inc) begin
         row_ff <= row_ff + 1'b1;
      end
   end

   assign status.row_done = (row_ff > row_hi_ff);

   // stage 1: screen and viewport clip
   assign pt_x = cmd.read_issue ? it_xs_ff : cur_x_ff;
   assign pt_y = cmd.read_issue ? it_ys_ff : cur_y_ff;
   assign xc   = CW'(pt_x);
   assign yc   = CW'(pt_y);

   assign on_scr  = (xc >= 0) && (xc < $signed(CW'(eff_w)))
                 && (yc >= 0) && (yc < $signed(CW'(eff_h)));
   assign in_view = (xc >= $signed(CW'(cfg.view_left)))
                 && (xc <= $signed(CW'(cfg.view_right)))
                 && (yc >= $signed(CW'(cfg.view_top)))
                 && (yc <= $signed(CW'(cfg.view_bottom)));
   assign plot_wr = cmd.step && it_style_ff[bit_ff] && on_scr && in_view;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_wr_ff <= 1'b0;
         s1_rd_ff <= 1'b0;
         s2_wr_ff <= 1'b0;
         s2_rd_ff <= 1'b0;
         s3_rd_ff <= 1'b0;
      end else begin
         s1_wr_ff <= plot_wr;
         s1_rd_ff <= cmd.read_issue;
         s2_wr_ff <= s1_wr_ff;
         s2_rd_ff <= s1_rd_ff;
         s3_rd_ff <= s2_rd_ff;
      end
   end

   // stage 2: row offset
   assign ya = AW'(s1_y_ff);
   assign wa = AW'(eff_w);

   always_ff @(posedge clock) begin
      s1_off_ff  <= !on_scr;
      s1_x_ff    <= pt_x[XW-1:0];
      s1_y_ff    <= pt_y[YW-1:0];
      s1_col_ff  <= it_col_ff;
      s2_off_ff  <= s1_off_ff;
      s2_x_ff    <= s1_x_ff;
      s2_prod_ff <= ya * wa;
      s2_col_ff  <= s1_col_ff;
      s3_off_ff  <= s2_off_ff;
   end

   // stage 3: address into the frame store
   assign fb_addr = s2_prod_ff + AW'(s2_x_ff);

   slbr_fb #(
      .DEPTH (DEPTH)
   ) u_fb (
      .clock    (clock),
      .reset    (reset),
      .we       (s2_wr_ff),
      .re       (s2_rd_ff && !s2_off_ff),
      .addr     (fb_addr),
      .wdata    (s2_col_ff),
      .rdata    (fb_rdata),
      .clr_busy (fb_busy)
   );

   always_ff @(posedge clock) begin
      if (s3_rd_ff) begin
         hold_pix_ff <= s3_off_ff ? '0 : fb_rdata;
         hold_off_ff <= s3_off_ff;
      end
      if (cmd.rsp_load) begin
         rsp_pixel_ff <= (it_op_ff == slbr_pkg::OP_READ) ? hold_pix_ff : '0;
         rsp_off_ff   <= (it_op_ff == slbr_pkg::OP_READ) ? hold_off_ff : 1'b0;
      end
   end

   assign status.op       = it_op_ff;
   assign status.rd_done  = s3_rd_ff;
   assign status.clr_busy = fb_busy;
   assign rsp_pixel       = rsp_pixel_ff;
   assign rsp_off         = rsp_off_ff;

endmodule

`default_nettype wire

>>> sv/styled_line_box_rasterizer_core.sv
// ----------------------------------------------------------------------------
// styled_line_box_rasterizer_core : styled line and box rasterizer
// Draws Bresenham lines, box outlines and filled boxes into a 4-bit frame
// store and reads single pixels back.
//
// req_ch carries one request per operation; rsp_ch returns one response
// per request, in order. The APB port sets screen size, viewport and
// default colour, and must be written only while the block is idle; the
// block itself does not enforce this. A read passes through the clip,
// row offset and memory read stages. One pixel per cycle is stepped by
// the Bresenham stepper while a segment runs, and written where its
// style bit is set; the single-port frame store takes one write or read
// a cycle.
// After reset the frame store is cleared one pixel a cycle, over all
// MAX_WIDTH*MAX_HEIGHT pixels (224000 by default); req_ch.ready stays low
// meanwhile. A response waits in an output register while rsp_ch is
// stalled; the next request is accepted, and held at its end until the
// register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module styled_line_box_rasterizer_core #(
   parameter int MAX_WIDTH  = 640,
   parameter int MAX_HEIGHT = 350
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   slbr_req_if.sink                                 req_ch,
   slbr_rsp_if.source                               rsp_ch,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [slbr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [slbr_pkg::CSR_DATA_W-1:0]     pwdata,
   output      logic [slbr_pkg::CSR_DATA_W-1:0]     prdata,
   output      logic                                pready
);

   slbr_pkg::cfg_type          cfg;
   slbr_pkg::item_type         req_item;
   slbr_pkg::cmd_type          cmd;
   slbr_pkg::status_type       status;
   logic                       req_ready;
   logic                       rsp_valid;
   logic [slbr_pkg::PIX_W-1:0] rsp_pixel;
   logic                       rsp_off;

   assign req_item.op         = req_ch.op;
   assign req_item.x_start    = req_ch.x_start;
   assign req_item.y_start    = req_ch.y_start;
   assign req_item.x_end      = req_ch.x_end;
   assign req_item.y_end      = req_ch.y_end;
   assign req_item.has_color  = req_ch.has_color;
   assign req_item.color      = req_ch.color;
   assign req_item.line_style = req_ch.line_style;

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.pixel_value = rsp_pixel;
   assign rsp_ch.off_screen  = rsp_off;

   slbr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   slbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   slbr_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_pixel (rsp_pixel),
      .rsp_off   (rsp_off)
   );

endmodule

`default_nettype wire
